### rtl/cltok_pkg.sv
// ----------------------------------------------------------------------------
// cltok_pkg
// shared types, character codes and helpers for the command line tokeniser
// ----------------------------------------------------------------------------
package cltok_pkg;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic FRAME_CMD = 1'b0;
    localparam logic FRAME_TOK = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;        // first byte of an item
        logic store_byte;   // ordinary byte while reading
        logic backspace;
        logic scan_begin;   // terminator on a non-empty item
        logic kind;         // frame kind latched at scan_begin
        logic scan_step;
        logic scan_end;
        logic a_done;       // first segment finished
        logic load_a;
        logic load_b;
        logic load_empty;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic letter;
        logic digit;
        logic minus;
        logic bs;
        logic term;
        logic fill_zero;
        logic ptr_at_fill;
        logic q_zero;
        logic ptr_at_a_end;
        logic ptr_at_b_end;
        logic none_emitted;
        logic slot_free;
    } dp_stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

### rtl/cltok_dp.sv
// ----------------------------------------------------------------------------
// cltok_dp
// line and command stores, scan pointer, frame bounds and result register
// ----------------------------------------------------------------------------
module cltok_dp import cltok_pkg::*; #(
    parameter int LINE_BYTES = 32,
    parameter int CMD_BYTES  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       res_stall,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic       res_valid,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       in_text_part,
    output logic       frame_kind,
    output logic [7:0] token_index,
    output logic       last_of_frame
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(CMD_BYTES);
    localparam int PW = (AW > CW) ? AW : CW;
    localparam logic [PW-1:0] FILL_MAX = PW'(LINE_BYTES - 1);
    localparam logic [PW-1:0] CMD_MAX  = PW'(CMD_BYTES - 1);

    logic [7:0]    line_mem [LINE_BYTES];
    logic [7:0]    cmd_mem  [CMD_BYTES];
    logic [7:0]    q_line_reg;
    logic [7:0]    q_cmd_reg;

    logic [PW-1:0] fill_reg, fill_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] sep_reg, sep_next;
    logic [PW-1:0] txt_reg, txt_next;
    logic          found_reg, found_next;
    logic          kind_reg, kind_next;
    logic [7:0]    count_reg, count_next;
    logic [CW-1:0] slen_reg, slen_next;
    logic          res_valid_reg, res_valid_next;

    logic [7:0]    char_reg;
    logic          cv_reg;
    logic          part_reg;
    logic          fk_reg;
    logic [7:0]    idx_reg;
    logic          last_reg;

    logic [PW-1:0] ptr_inc;
    logic [PW-1:0] a_end;
    logic [PW-1:0] b_start;
    logic          b_empty;
    logic          slot_free;
    logic          do_load;
    logic [AW-1:0] wr_addr;
    logic          line_wr;

    assign ptr_inc   = ptr_reg + 1'b1;
    assign a_end     = kind_reg ? PW'(slen_reg) : sep_reg;
    assign b_start   = kind_reg ? '0 : txt_reg;
    assign b_empty   = (b_start == len_reg);
    assign slot_free = !res_valid_reg || !res_stall;
    assign do_load   = cmd.load_a || cmd.load_b || cmd.load_empty;
    assign wr_addr   = cmd.start ? '0 : fill_reg[AW-1:0];
    assign line_wr   = cmd.start || (cmd.store_byte && (fill_reg < FILL_MAX));

    always_comb
    begin
        stat.letter       = is_letter(in_byte);
        stat.digit        = is_digit(in_byte);
        stat.minus        = (in_byte == CH_MINUS);
        stat.bs           = (in_byte == CH_BS);
        stat.term         = (in_byte == CH_LF) || (in_byte == CH_CR) || (in_byte == CH_SEMI);
        stat.fill_zero    = (fill_reg == '0);
        stat.ptr_at_fill  = (ptr_reg == fill_reg);
        stat.q_zero       = (q_line_reg == CH_NUL);
        stat.ptr_at_a_end = (ptr_reg == a_end);
        stat.ptr_at_b_end = (ptr_reg == len_reg);
        stat.none_emitted = (a_end == '0) && b_empty;
        stat.slot_free    = slot_free;
    end

    // stores, registered read every cycle at the pointer
    always_ff @(posedge clk)
    begin
        if (line_wr)
        begin
            line_mem[wr_addr] <= in_byte;
        end
        if (cmd.load_a && (kind_reg == FRAME_CMD) && (ptr_reg < CMD_MAX))
        begin
            cmd_mem[ptr_reg[CW-1:0]] <= q_line_reg;
        end
        q_line_reg <= line_mem[ptr_reg[AW-1:0]];
        q_cmd_reg  <= cmd_mem[ptr_reg[CW-1:0]];
    end

    always_comb
    begin
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        len_next       = len_reg;
        sep_next       = sep_reg;
        txt_next       = txt_reg;
        found_next     = found_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        slen_next      = slen_reg;
        res_valid_next = res_valid_reg;

        if (cmd.start)
        begin
            fill_next = PW'(1);
        end
        else if (line_wr)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.backspace && (fill_reg != '0))
        begin
            fill_next = fill_reg - 1'b1;
        end

        if (cmd.scan_begin)
        begin
            ptr_next   = '0;
            found_next = 1'b0;
            kind_next  = cmd.kind;
            if (cmd.kind == FRAME_CMD)
            begin
                count_next = '0;
            end
            else if (count_reg != 8'hFF)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.scan_step)
        begin
            ptr_next = ptr_inc;
            if (!found_reg && ((q_line_reg == CH_SPACE) || (q_line_reg == CH_COLON)))
            begin
                sep_next   = ptr_reg;
                txt_next   = ptr_inc;
                found_next = 1'b1;
            end
            else if (found_reg && (q_line_reg == CH_SPACE) && (txt_reg == ptr_reg))
            begin
                txt_next = ptr_inc;
            end
        end
        else if (cmd.scan_end)
        begin
            ptr_next = '0;
            len_next = ptr_reg;
            if (!found_reg)
            begin
                sep_next = ptr_reg;
                txt_next = ptr_reg;
            end
        end
        else if (cmd.a_done)
        begin
            ptr_next = b_start;
            if (kind_reg == FRAME_CMD)
            begin
                slen_next = (sep_reg < CMD_MAX) ? sep_reg[CW-1:0] : CMD_MAX[CW-1:0];
            end
        end
        else if (cmd.load_a || cmd.load_b)
        begin
            ptr_next = ptr_inc;
        end

        if (do_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            len_reg       <= '0;
            sep_reg       <= '0;
            txt_reg       <= '0;
            found_reg     <= 1'b0;
            kind_reg      <= FRAME_CMD;
            count_reg     <= '0;
            slen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            len_reg       <= len_next;
            sep_reg       <= sep_next;
            txt_reg       <= txt_next;
            found_reg     <= found_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            slen_reg      <= slen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            fk_reg  <= kind_reg;
            idx_reg <= count_reg;
            if (cmd.load_a)
            begin
                char_reg <= kind_reg ? q_cmd_reg : q_line_reg;
                cv_reg   <= 1'b1;
                part_reg <= 1'b0;
                last_reg <= (ptr_inc == a_end) && b_empty;
            end
            else if (cmd.load_b)
            begin
                char_reg <= q_line_reg;
                cv_reg   <= 1'b1;
                part_reg <= 1'b1;
                last_reg <= (ptr_inc == len_reg);
            end
            else
            begin
                char_reg <= CH_NUL;
                cv_reg   <= 1'b0;
                part_reg <= 1'b0;
                last_reg <= 1'b1;
            end
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_char      = char_reg;
    assign char_valid    = cv_reg;
    assign in_text_part  = part_reg;
    assign frame_kind    = fk_reg;
    assign token_index   = idx_reg;
    assign last_of_frame = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill level beyond store size");

    a_slen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slen_reg <= CMD_MAX)
        else $error("saved command length beyond limit");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |-> slot_free)
        else $error("result loaded over a held result");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load_a, cmd.load_b, cmd.load_empty, cmd.start, cmd.scan_begin}) <= 1)
        else $error("conflicting datapath commands");

endmodule

### rtl/cltok_ctrl.sv
// ----------------------------------------------------------------------------
// cltok_ctrl
// sequencer: byte intake, store scan and result emission
// ----------------------------------------------------------------------------
module cltok_ctrl import cltok_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_CMD,
        S_READ_TOK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_A_CHK,
        S_A_RD,
        S_A_EM,
        S_B_CHK,
        S_B_RD,
        S_B_EM,
        S_EMPTY
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign byte_stall = !((state_reg == S_IDLE) || (state_reg == S_READ_CMD) ||
                          (state_reg == S_READ_TOK));
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (stat.letter || stat.digit || stat.minus))
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.letter ? S_READ_CMD : S_READ_TOK;
                end
            end
            S_READ_CMD, S_READ_TOK:
            begin
                if (accept)
                begin
                    priority if (stat.bs)
                    begin
                        cmd.backspace = 1'b1;
                    end
                    else if (stat.term)
                    begin
                        if (stat.fill_zero)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_begin = 1'b1;
                            cmd.kind       = (state_reg == S_READ_TOK) ? FRAME_TOK : FRAME_CMD;
                            state_next     = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (stat.ptr_at_fill)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = S_A_CHK;
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (stat.q_zero)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = S_A_CHK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_A_CHK:
            begin
                if (stat.ptr_at_a_end)
                begin
                    cmd.a_done = 1'b1;
                    state_next = S_B_CHK;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_EM;
            end
            S_A_EM:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_a = 1'b1;
                    state_next = S_A_CHK;
                end
            end
            S_B_CHK:
            begin
                if (stat.ptr_at_b_end)
                begin
                    state_next = stat.none_emitted ? S_EMPTY : S_IDLE;
                end
                else
                begin
                    state_next = S_B_RD;
                end
            end
            S_B_RD:
            begin
                state_next = S_B_EM;
            end
            S_B_EM:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_b = 1'b1;
                    state_next = S_B_CHK;
                end
            end
            S_EMPTY:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMPTY) |-> stat.none_emitted)
        else $error("empty result with bytes to emit");

    a_scan_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_begin |=> (state_reg == S_SCAN_RD) && byte_stall)
        else $error("scan did not start after terminator");

endmodule

### rtl/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// byte-serial splitter of command lines and numeric tokens into result beats
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  input     in   byte_valid / byte_stall    in_byte
//  result    out  res_valid / res_stall      out_char, char_valid, in_text_part,
//                                            frame_kind, token_index, last_of_frame
//
//  an ordinary byte is taken back to back
//  a terminator on a non-empty item starts a scan of the line store, each stored
//  byte read, then evaluated, up to the first zero byte or the fill level; then
//  each result beat is checked against its segment end, read and loaded; each
//  store has a single read port; input stays stalled from the terminator until
//  the sequencer is back in idle, after the last beat of the frame is loaded
//  rst_n clears asynchronously; stores hold no reset and need no clearing pass
//  a stalled result beat holds, other work waits on res_stall only when loading
// ----------------------------------------------------------------------------
module command_line_tokenizer import cltok_pkg::*; #(
    parameter int LINE_BYTES = 32,
    parameter int CMD_BYTES  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       in_text_part,
    output logic       frame_kind,
    output logic [7:0] token_index,
    output logic       last_of_frame
);

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: intake modes, scan loop and emission of both segments
    cltok_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: stores, pointer, frame bounds, token count and result register
    cltok_dp #(
        .LINE_BYTES (LINE_BYTES),
        .CMD_BYTES  (CMD_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .res_stall     (res_stall),
        .cmd           (cmd),
        .stat          (stat),
        .res_valid     (res_valid),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .in_text_part  (in_text_part),
        .frame_kind    (frame_kind),
        .token_index   (token_index),
        .last_of_frame (last_of_frame)
    );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the command line tokeniser: a queue-fed byte driver
// and a result monitor with random gaps and stalls, checked against an
// in-bench model of the line store, the command split and the token counter
// ----------------------------------------------------------------------------
module tb import cltok_pkg::*; ();

    localparam int LINE_BYTES     = 32;
    localparam int CMD_BYTES      = 16;
    localparam int RANDOM_BEATS   = 290;   // random input beats that do real work
    localparam int TOKEN_STREAK   = 40;    // a run of tokens under one command
    localparam int LONG_HOLD_AT   = 60;    // result count at which the receiver holds off
    localparam int LONG_HOLD      = 250;
    localparam int SETTLE_CYCLES  = 300;   // covers a full scan plus the longest frame
    localparam int WATCHDOG_LIMIT = 4000;

    // parser modes of the bench model
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CMD,
        MODE_TOK
    } line_mode_t;

    // one byte waiting to be sent
    typedef struct {
        logic [7:0] b;
        int         gap;     // idle cycles before it is offered
        bit         drain;   // hold it back until every result is in
    } rx_char_t;

    // one result beat
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       text_part;
        logic       kind;
        logic [7:0] idx;
        logic       last;
    } res_beat_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] in_byte    = 8'h00;
    logic       res_valid;
    logic       res_stall  = 1'b0;
    logic [7:0] out_char;
    logic       char_valid;
    logic       in_text_part;
    logic       frame_kind;
    logic [7:0] token_index;
    logic       last_of_frame;

    command_line_tokenizer #(
        .LINE_BYTES (LINE_BYTES),
        .CMD_BYTES  (CMD_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .in_byte       (in_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .in_text_part  (in_text_part),
        .frame_kind    (frame_kind),
        .token_index   (token_index),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bench model state
    // ------------------------------------------------------------------------
    line_mode_t  mdl_mode   = MODE_IDLE;
    logic [7:0]  mdl_store [LINE_BYTES];
    int          mdl_fill   = 0;
    logic [7:0]  mdl_cmd [CMD_BYTES];
    int          mdl_cmd_len = 0;
    logic [7:0]  mdl_tokens = 8'h00;

    rx_char_t    chars_to_send [$];
    res_beat_t   beats_due [$];      // predicted, not yet matched
    res_beat_t   beats_seen [$];     // received, not yet matched

    // statistics and error counts
    int          mismatches   = 0;
    int          beats_in     = 0;
    int          beats_out    = 0;
    int          beats_checked = 0;
    int          cmd_frames   = 0;
    int          tok_frames   = 0;
    int          empty_frames = 0;
    logic [7:0]  peak_index   = 8'h00;

    // stimulus pacing
    int          send_run_left = 0;
    bit          send_eager    = 1'b0;
    bit          drain_next    = 1'b0;

    function automatic bit is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic void due_beat(input logic [7:0] ch, input logic has_char,
                                     input logic text_part, input logic kind,
                                     input logic [7:0] idx, input logic last);
        res_beat_t r;
        r.ch        = ch;
        r.has_char  = has_char;
        r.text_part = text_part;
        r.kind      = kind;
        r.idx       = idx;
        r.last      = last;
        beats_due.push_back(r);
        if (idx > peak_index)
            peak_index = idx;
    endfunction

    // advance the model by one accepted byte and queue the beats it causes
    function automatic void split_line_byte(input logic [7:0] b);
        int         len;
        int         sep;
        int         txt;
        int         n;
        int         k;
        logic       kind;
        logic [7:0] idx;
        if (mdl_mode != MODE_CMD && mdl_mode != MODE_TOK)
        begin
            // waiting: only a letter, digit or minus opens an item
            if (is_alpha(b) || is_num(b) || b == CH_MINUS)
            begin
                mdl_mode     = is_alpha(b) ? MODE_CMD : MODE_TOK;
                mdl_store[0] = b;
                mdl_fill     = 1;
            end
        end
        else if (b == CH_BS)
        begin
            if (mdl_fill != 0)
                mdl_fill--;
        end
        else if (b == CH_LF || b == CH_CR || b == CH_SEMI)
        begin
            kind     = (mdl_mode == MODE_TOK) ? FRAME_TOK : FRAME_CMD;
            mdl_mode = MODE_IDLE;
            if (mdl_fill != 0)
            begin
                // the item stops at the first stored zero
                len = 0;
                while (len < mdl_fill && mdl_store[len] != CH_NUL)
                    len++;
                mdl_fill = 0;
                k        = 0;
                if (kind == FRAME_CMD)
                begin
                    sep = 0;
                    while (sep < len && mdl_store[sep] != CH_SPACE && mdl_store[sep] != CH_COLON)
                        sep++;
                    txt = len;
                    if (sep < len)
                    begin
                        txt = sep + 1;
                        while (txt < len && mdl_store[txt] == CH_SPACE)
                            txt++;
                    end
                    idx         = 8'h00;
                    mdl_tokens  = 8'h00;
                    mdl_cmd_len = (sep < CMD_BYTES - 1) ? sep : CMD_BYTES - 1;
                    for (int i = 0; i < mdl_cmd_len; i++)
                        mdl_cmd[i] = mdl_store[i];
                    n = sep + len - txt;
                    for (int i = 0; i < sep; i++)
                    begin
                        due_beat(mdl_store[i], 1'b1, 1'b0, kind, idx, k == n - 1);
                        k++;
                    end
                    for (int i = txt; i < len; i++)
                    begin
                        due_beat(mdl_store[i], 1'b1, 1'b1, kind, idx, k == n - 1);
                        k++;
                    end
                    cmd_frames++;
                end
                else
                begin
                    if (mdl_tokens != 8'hFF)
                        mdl_tokens++;
                    idx = mdl_tokens;
                    n   = mdl_cmd_len + len;
                    for (int i = 0; i < mdl_cmd_len; i++)
                    begin
                        due_beat(mdl_cmd[i], 1'b1, 1'b0, kind, idx, k == n - 1);
                        k++;
                    end
                    for (int i = 0; i < len; i++)
                    begin
                        due_beat(mdl_store[i], 1'b1, 1'b1, kind, idx, k == n - 1);
                        k++;
                    end
                    tok_frames++;
                end
                // nothing left after the split: a single empty closing beat
                if (n == 0)
                begin
                    due_beat(CH_NUL, 1'b0, 1'b0, kind, idx, 1'b1);
                    empty_frames++;
                end
            end
        end
        else if (mdl_fill < LINE_BYTES - 1)
        begin
            mdl_store[mdl_fill] = b;
            mdl_fill++;
        end
    endfunction

    // pair received beats with predicted ones in order
    function automatic void match_beats();
        res_beat_t want;
        res_beat_t got;
        while (beats_due.size() != 0 && beats_seen.size() != 0)
        begin
            want = beats_due.pop_front();
            got  = beats_seen.pop_front();
            if (want.ch !== got.ch || want.has_char !== got.has_char
                || want.text_part !== got.text_part || want.kind !== got.kind
                || want.idx !== got.idx || want.last !== got.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d wrong: expected char %02h valid %b text %b kind %b %s",
                             beats_checked, want.ch, want.has_char, want.text_part,
                             want.kind, "");
                    $display("  expected idx %0d last %b", want.idx, want.last);
                    $display("  got char %02h valid %b text %b kind %b idx %0d last %b",
                             got.ch, got.has_char, got.text_part, got.kind,
                             got.idx, got.last);
                end
            end
            beats_checked++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b);
        rx_char_t c;
        // alternate stretches of back-to-back bytes with stretches of random gaps
        if (send_run_left == 0)
        begin
            send_run_left = $urandom_range(8, 40);
            send_eager    = ($urandom_range(0, 2) == 0);
        end
        send_run_left--;
        c.b        = b;
        c.gap      = send_eager ? 0 : $urandom_range(0, 15);
        c.drain    = drain_next;
        drain_next = 1'b0;
        chars_to_send.push_back(c);
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                    : 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [7:0] any_terminator();
        case ($urandom_range(0, 2))
            0:       return CH_LF;
            1:       return CH_CR;
            default: return CH_SEMI;
        endcase
    endfunction

    // body byte of a line: mostly text, now and then an edit or an odd byte
    function automatic logic [7:0] body_byte(input bit in_args);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return CH_BS;
        else if (roll < 8)
            return CH_NUL;
        else if (roll < 13)
            return 8'($urandom_range(128, 255));
        else if (in_args && roll < 23)
            return CH_SPACE;
        else if (in_args && roll < 27)
            return CH_COLON;
        else if (roll < 60)
            return any_digit();
        else
            return any_letter();
    endfunction

    // returns the number of bytes queued
    function automatic int queue_command(input bit long_line);
        int name_len;
        int arg_len;
        int gap_spaces;
        int count;
        name_len = long_line ? $urandom_range(14, 24) : $urandom_range(1, 6);
        arg_len  = long_line ? $urandom_range(10, 30) : $urandom_range(0, 8);
        queue_byte(any_letter());
        count = 1;
        for (int i = 1; i < name_len; i++)
        begin
            queue_byte(body_byte(1'b0));
            count++;
        end
        case ($urandom_range(0, 9))
            0:       ;
            1, 2, 3, 4, 5, 6:
            begin
                queue_byte(CH_SPACE);
                count++;
            end
            default:
            begin
                queue_byte(CH_COLON);
                count++;
            end
        endcase
        gap_spaces = $urandom_range(0, 3);
        for (int i = 0; i < gap_spaces; i++)
            queue_byte(CH_SPACE);
        for (int i = 0; i < arg_len; i++)
            queue_byte(body_byte(1'b1));
        queue_byte(any_terminator());
        return count + gap_spaces + arg_len + 1;
    endfunction

    function automatic int queue_token();
        int tail;
        tail = $urandom_range(0, 6);
        queue_byte($urandom_range(0, 3) == 0 ? CH_MINUS : any_digit());
        for (int i = 0; i < tail; i++)
        begin
            case ($urandom_range(0, 19))
                0:       queue_byte(CH_BS);
                1:       queue_byte(CH_NUL);
                2:       queue_byte(8'h2E);
                3:       queue_byte(8'h65);
                default: queue_byte(any_digit());
            endcase
        end
        queue_byte(any_terminator());
        return tail + 2;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued bytes, counts gaps, holds a drain point
    // ------------------------------------------------------------------------
    int       send_gap   = 0;
    bit       gap_armed  = 1'b0;
    logic     offering;
    bit       load_next;
    rx_char_t next_char;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            in_byte    <= 8'h00;
            send_gap   = 0;
            gap_armed  = 1'b0;
        end
        else
        begin
            offering  = byte_valid;
            load_next = 1'b0;
            if (byte_valid && !byte_stall)
            begin
                // byte taken: model first, then try to pair up
                split_line_byte(in_byte);
                beats_in++;
                offering = 1'b0;
                match_beats();
            end
            if (!offering && chars_to_send.size() != 0)
            begin
                if (!gap_armed)
                begin
                    send_gap  = chars_to_send[0].gap;
                    gap_armed = 1'b1;
                end
                if (send_gap != 0)
                    send_gap--;
                else if (!chars_to_send[0].drain || beats_due.size() == 0)
                begin
                    // a drain point waits here until every predicted beat is in
                    next_char = chars_to_send.pop_front();
                    offering  = 1'b1;
                    load_next = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            byte_valid <= offering;
            if (load_next)
                in_byte <= next_char.b;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: takes result beats with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    int        hold_left    = 0;
    int        rcv_run_left = 0;
    bit        rcv_eager    = 1'b0;
    res_beat_t got_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got_beat.ch        = out_char;
                got_beat.has_char  = char_valid;
                got_beat.text_part = in_text_part;
                got_beat.kind      = frame_kind;
                got_beat.idx       = token_index;
                got_beat.last      = last_of_frame;
                beats_seen.push_back(got_beat);
                beats_out++;
                match_beats();
                if (rcv_run_left == 0)
                begin
                    rcv_run_left = $urandom_range(8, 40);
                    rcv_eager    = ($urandom_range(0, 2) == 0);
                end
                rcv_run_left--;
                hold_left = rcv_eager ? 0 : $urandom_range(0, 15);
                // one long hold-off so the block backs up into its input
                if (beats_out == LONG_HOLD_AT)
                    hold_left = LONG_HOLD;
            end
            else if (hold_left != 0)
                hold_left--;
            res_stall <= (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when no beat moves for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, beats_due.size());
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    int  useful;
    int  seq;
    bit  streak_done;
    int  stray;
    int  noise_len;

    initial
    begin
        // directed: bytes ignored while waiting
        queue_byte(CH_NUL);
        queue_byte(8'hFF);
        queue_byte(CH_BS);
        queue_byte(CH_SEMI);
        // letter extremes, colon split, skipped space, carriage return
        queue_text("Zz: x");
        queue_byte(CH_CR);
        // minus-led token after that command
        queue_text("-9");
        queue_byte(CH_LF);
        // token erased back to nothing: no output
        queue_text("0");
        queue_byte(CH_BS);
        queue_byte(CH_SEMI);
        // stored zero cuts the line short
        queue_text("a");
        queue_byte(CH_NUL);
        queue_text("b");
        queue_byte(CH_LF);
        // empty command beat, then empty token beat with an empty saved command
        queue_text("a");
        queue_byte(CH_BS);
        queue_byte(CH_NUL);
        queue_byte(CH_LF);
        queue_text("7");
        queue_byte(CH_BS);
        queue_byte(CH_NUL);
        queue_byte(CH_SEMI);

        // random part: mostly well-formed lines and tokens, some noise
        useful      = 0;
        seq         = 0;
        streak_done = 1'b0;
        drain_next  = 1'b1;
        while (useful < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 24) == 0)
                drain_next = 1'b1;
            if (!streak_done && useful >= RANDOM_BEATS / 2)
            begin
                // a long run of tokens under one command walks the index up
                queue_text("q");
                queue_byte(CH_LF);
                for (int i = 0; i < TOKEN_STREAK; i++)
                begin
                    queue_byte(any_digit());
                    queue_byte(any_terminator());
                end
                streak_done = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    // noise, may open an item by chance
                    noise_len = $urandom_range(1, 4);
                    for (int i = 0; i < noise_len; i++)
                        queue_byte(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    // broken item: opened but never closed
                    queue_byte(any_letter());
                    queue_byte(body_byte(1'b1));
                    useful += 2;
                end
                3, 4, 5, 6, 7, 8, 9, 10, 11:
                    useful += queue_command(seq == 0 || $urandom_range(0, 7) == 0);
                default:
                    useful += queue_token();
            endcase
            seq++;
        end

        // reset held, then released away from the rising edge
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for the sender, then for every predicted beat, then settle
        while (chars_to_send.size() != 0 || byte_valid)
            @(posedge clk);
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        // anything received with nothing predicted is a failure
        stray = beats_seen.size();
        if (stray != 0)
        begin
            mismatches += stray;
            $display("%0d result beats arrived with no prediction waiting", stray);
        end

        $display("covered %0d input bytes and %0d result beats (%0d checked)",
                 beats_in, beats_out, beats_checked);
        $display("frames: %0d command, %0d token, %0d empty; highest token index %0d",
                 cmd_frames, tok_frames, empty_frames, peak_index);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/cltok_pkg.sv
rtl/cltok_dp.sv
rtl/cltok_ctrl.sv
rtl/command_line_tokenizer.sv
bench/tb.sv
